### design/qmmt_pkg.sv
package qmmt_pkg;

	localparam int MAX_CYCLES_DEF  = 512;
	localparam int QUAL_BINS_DEF   = 64;
	localparam int COUNT_WIDTH_DEF = 32;

	localparam logic [7:0] PHRED_OFFSET   = 8'd33;
	localparam logic [7:0] LOW_EDIT_LIMIT = 8'd2;
	localparam logic [5:0] QUAL_SAT       = 6'd63;

	localparam logic [7:0] CH_M = 8'h4D;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_I = 8'h49;

	localparam logic [1:0] CFG_FIRST  = 2'd0;
	localparam logic [1:0] CFG_SECOND = 2'd1;
	localparam logic [1:0] CFG_PAIRED = 2'd2;

	localparam logic [2:0] TSEL_ALL     = 3'd0;
	localparam logic [2:0] TSEL_LOW     = 3'd1;
	localparam logic [2:0] TSEL_BASE_A  = 3'd2;
	localparam logic [2:0] TSEL_BASE_C  = 3'd3;
	localparam logic [2:0] TSEL_BASE_G  = 3'd4;
	localparam logic [2:0] TSEL_BASE_T  = 3'd5;
	localparam logic [2:0] TSEL_CYC_ALL = 3'd6;
	localparam logic [2:0] TSEL_CYC_LOW = 3'd7;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SKIP     = 3'd1,
		ST_BAD_SYM  = 3'd2,
		ST_UNPAIRED = 3'd3,
		ST_RANGE    = 3'd4
	} qmmt_status_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_LOOK
	} qmmt_state_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] qual_char;
		logic [7:0] aligned_symbol;
		logic [7:0] read_base;
		logic [8:0] read_offset;
		logic       second_mate;
		logic       reverse_strand;
		logic [7:0] edit_distance;
		logic       masked;
		logic [2:0] table_select;
		logic [5:0] read_quality;
		logic [8:0] read_cycle;
	} qmmt_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] match_count;
		logic [31:0] mismatch_count;
		logic [5:0]  max_quality;
	} qmmt_out_t;

	// classification carried from front to back
	typedef struct packed {
		qmmt_status_t status;
		logic         rd;
		logic         cnt;
		logic         kind;
		logic         low_edit;
		logic         base_ok;
		logic [2:0]   sel;
	} qmmt_ctl_t;

endpackage

### design/qmmt_front.sv
module qmmt_front #(
	parameter int MAX_CYCLES = qmmt_pkg::MAX_CYCLES_DEF,
	parameter int QUAL_BINS  = qmmt_pkg::QUAL_BINS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [9:0]              cfg_data,
	input  qmmt_pkg::qmmt_in_t      in_data,
	output qmmt_pkg::qmmt_ctl_t     ctl,
	output logic [$clog2(QUAL_BINS)-1:0]              qaddr,
	output logic [$clog2(4*QUAL_BINS)-1:0]            baddr,
	output logic [$clog2(MAX_CYCLES*QUAL_BINS)-1:0]   caddr
);
	import qmmt_pkg::*;

	localparam int QAW = $clog2(QUAL_BINS);
	localparam int BAW = $clog2(4*QUAL_BINS);
	localparam int CAW = $clog2(MAX_CYCLES*QUAL_BINS);

	logic [9:0]   first_q, second_q;
	logic         paired_q;
	logic [7:0]   phred, bin;
	logic         sym_match, sym_mis, qual_bad, base_known;
	logic [1:0]   base_t, tsel;
	logic [12:0]  f13, s13, o13, cycle;
	logic [10:0]  rows, rows_cap;
	logic [10:0]  row;
	logic         cyc_bad;
	qmmt_status_t st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			second_q <= '0;
			paired_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIRST:  first_q  <= cfg_data;
				CFG_SECOND: second_q <= cfg_data;
				CFG_PAIRED: paired_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		phred      = in_data.qual_char - PHRED_OFFSET;
		sym_match  = (in_data.aligned_symbol == CH_M);
		sym_mis    = (in_data.aligned_symbol == CH_A) || (in_data.aligned_symbol == CH_C) ||
		             (in_data.aligned_symbol == CH_G) || (in_data.aligned_symbol == CH_T);
		qual_bad   = (in_data.qual_char < PHRED_OFFSET) || (9'(phred) >= 9'(QUAL_BINS));

		base_known = 1'b1;
		base_t     = 2'd0;
		case (in_data.read_base)
			CH_A:    base_t = 2'd0;
			CH_C:    base_t = 2'd1;
			CH_G:    base_t = 2'd2;
			CH_T:    base_t = 2'd3;
			default: base_known = 1'b0;
		endcase
		if (in_data.reverse_strand) begin
			base_t = 2'd3 - base_t;
		end

		f13 = 13'(first_q);
		s13 = 13'(second_q);
		o13 = 13'(in_data.read_offset);
		if (in_data.second_mate) begin
			cycle = in_data.reverse_strand ? f13 + s13 - o13 - 13'd1 : f13 + o13;
		end else begin
			cycle = in_data.reverse_strand ? f13 - o13 - 13'd1 : o13;
		end
		rows     = 11'(first_q) + (paired_q ? 11'(second_q) : 11'd0);
		rows_cap = (rows > 11'(MAX_CYCLES)) ? 11'(MAX_CYCLES) : rows;
		cyc_bad  = cycle[12] || (cycle[11:0] >= 12'(rows_cap));

		if (in_data.masked) begin
			st = ST_SKIP;
		end else if (in_data.second_mate && !paired_q) begin
			st = ST_UNPAIRED;
		end else if (in_data.aligned_symbol == CH_S || in_data.aligned_symbol == CH_I) begin
			st = ST_SKIP;
		end else if (!sym_match && !sym_mis) begin
			st = ST_BAD_SYM;
		end else if (qual_bad || cyc_bad) begin
			st = ST_RANGE;
		end else begin
			st = ST_OK;
		end

		ctl.sel      = in_data.table_select;
		ctl.rd       = in_data.cmd;
		ctl.kind     = sym_mis;
		ctl.low_edit = (in_data.edit_distance <= LOW_EDIT_LIMIT);
		ctl.base_ok  = base_known;
		if (in_data.cmd) begin
			// read back one bin
			bin  = 8'(in_data.read_quality);
			row  = 11'(in_data.read_cycle);
			tsel = 2'(in_data.table_select - TSEL_BASE_A);
			if (9'(in_data.read_quality) >= 9'(QUAL_BINS) ||
			    (in_data.table_select >= TSEL_CYC_ALL &&
			     11'(in_data.read_cycle) >= 11'(MAX_CYCLES))) begin
				ctl.status = ST_RANGE;
			end else begin
				ctl.status = ST_OK;
			end
			ctl.cnt = 1'b0;
		end else begin
			bin        = phred;
			row        = cycle[10:0];
			tsel       = base_t;
			ctl.status = st;
			ctl.cnt    = (st == ST_OK);
		end

		qaddr = QAW'(bin);
		baddr = BAW'(32'(tsel) * 32'(QUAL_BINS) + 32'(bin));
		caddr = CAW'(32'(row) * 32'(QUAL_BINS) + 32'(bin));
	end

endmodule

### design/qmmt_fifo.sv
module qmmt_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] head
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

### design/qmmt_back.sv
module qmmt_back #(
	parameter int MAX_CYCLES  = qmmt_pkg::MAX_CYCLES_DEF,
	parameter int QUAL_BINS   = qmmt_pkg::QUAL_BINS_DEF,
	parameter int COUNT_WIDTH = qmmt_pkg::COUNT_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	output logic                    q_pop,
	input  qmmt_pkg::qmmt_ctl_t     q_ctl,
	input  logic [$clog2(QUAL_BINS)-1:0]            q_qaddr,
	input  logic [$clog2(4*QUAL_BINS)-1:0]          q_baddr,
	input  logic [$clog2(MAX_CYCLES*QUAL_BINS)-1:0] q_caddr,
	output logic                    clearing,
	output logic                    out_valid,
	input  logic                    out_ready,
	output qmmt_pkg::qmmt_out_t     out_data
);
	import qmmt_pkg::*;

	localparam int QAW       = $clog2(QUAL_BINS);
	localparam int BAW       = $clog2(4*QUAL_BINS);
	localparam int CAW       = $clog2(MAX_CYCLES*QUAL_BINS);
	localparam int CYC_DEPTH = MAX_CYCLES * QUAL_BINS;
	localparam int BASE_DEPTH = 4 * QUAL_BINS;
	localparam int CLR_DEPTH = (CYC_DEPTH > BASE_DEPTH) ? CYC_DEPTH : BASE_DEPTH;
	localparam int CLW       = $clog2(CLR_DEPTH);
	localparam int EW        = 2 * COUNT_WIDTH;

	// entry layout: {mismatch, match}
	logic [EW-1:0] sum_all  [QUAL_BINS];
	logic [EW-1:0] sum_low  [QUAL_BINS];
	logic [EW-1:0] sum_base [BASE_DEPTH];
	logic [EW-1:0] cyc_all  [CYC_DEPTH];
	logic [EW-1:0] cyc_low  [CYC_DEPTH];

	logic [EW-1:0] rd_all_q, rd_low_q, rd_base_q, rd_call_q, rd_clow_q;

	qmmt_state_t   state_q, state_d;
	logic [CLW-1:0] clr_q;
	qmmt_ctl_t     ctl_q;
	logic [QAW-1:0] qaddr_q;
	logic [BAW-1:0] baddr_q;
	logic [CAW-1:0] caddr_q;
	logic [5:0]    hq_q, hq_d;
	logic          out_valid_q;
	qmmt_out_t     out_q;

	logic          fire, clr_last;
	logic          we_sum, we_low, we_base, we_call, we_clow;
	logic [QAW-1:0] wa_q;
	logic [BAW-1:0] wa_b;
	logic [CAW-1:0] wa_c;
	logic [EW-1:0] wd_all, wd_low, wd_base, wd_call, wd_clow;
	logic [EW-1:0] sel_entry;

	function automatic logic [EW-1:0] bump(input logic [EW-1:0] e, input logic kind);
		logic [COUNT_WIDTH-1:0] mc, mm;
		mc = e[COUNT_WIDTH-1:0];
		mm = e[EW-1:COUNT_WIDTH];
		if (kind) begin
			if (~&mm) mm = mm + 1'b1;
		end else begin
			if (~&mc) mc = mc + 1'b1;
		end
		return {mm, mc};
	endfunction

	assign clearing  = (state_q == BK_CLEAR);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign clr_last  = (clr_q == CLW'(CLR_DEPTH - 1));

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		fire    = 1'b0;
		we_sum  = 1'b0;
		we_low  = 1'b0;
		we_base = 1'b0;
		we_call = 1'b0;
		we_clow = 1'b0;
		wa_q    = qaddr_q;
		wa_b    = baddr_q;
		wa_c    = caddr_q;
		wd_all  = bump(rd_all_q, ctl_q.kind);
		wd_low  = bump(rd_low_q, ctl_q.kind);
		wd_base = bump(rd_base_q, ctl_q.kind);
		wd_call = bump(rd_call_q, ctl_q.kind);
		wd_clow = bump(rd_clow_q, ctl_q.kind);
		hq_d    = hq_q;
		unique case (state_q)
			BK_CLEAR: begin
				wa_q    = clr_q[QAW-1:0];
				wa_b    = clr_q[BAW-1:0];
				wa_c    = clr_q[CAW-1:0];
				wd_all  = '0;
				wd_low  = '0;
				wd_base = '0;
				wd_call = '0;
				wd_clow = '0;
				we_sum  = (32'(clr_q) < 32'(QUAL_BINS));
				we_low  = we_sum;
				we_base = (32'(clr_q) < 32'(BASE_DEPTH));
				we_call = (32'(clr_q) < 32'(CYC_DEPTH));
				we_clow = we_call;
				if (clr_last) state_d = BK_IDLE;
			end
			BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = BK_LOOK;
				end
			end
			BK_LOOK: begin
				fire = !out_valid_q || out_ready;
				if (fire) begin
					state_d = BK_IDLE;
					if (ctl_q.cnt) begin
						we_sum  = 1'b1;
						we_low  = ctl_q.low_edit;
						we_base = ctl_q.base_ok;
						we_call = 1'b1;
						we_clow = ctl_q.low_edit;
						if (9'(qaddr_q) > 9'(hq_q)) begin
							hq_d = (9'(qaddr_q) > 9'(QUAL_SAT)) ? QUAL_SAT : 6'(qaddr_q);
						end
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		case (ctl_q.sel)
			TSEL_ALL:     sel_entry = rd_all_q;
			TSEL_LOW:     sel_entry = rd_low_q;
			TSEL_CYC_ALL: sel_entry = rd_call_q;
			TSEL_CYC_LOW: sel_entry = rd_clow_q;
			default:      sel_entry = rd_base_q;
		endcase
	end

	// counter memories: registered read on pop, write-back on completion
	always_ff @(posedge clk) begin
		if (q_pop) begin
			rd_all_q  <= sum_all[q_qaddr];
			rd_low_q  <= sum_low[q_qaddr];
			rd_base_q <= sum_base[q_baddr];
			rd_call_q <= cyc_all[q_caddr];
			rd_clow_q <= cyc_low[q_caddr];
		end
		if (we_sum)  sum_all[wa_q]  <= wd_all;
		if (we_low)  sum_low[wa_q]  <= wd_low;
		if (we_base) sum_base[wa_b] <= wd_base;
		if (we_call) cyc_all[wa_c]  <= wd_call;
		if (we_clow) cyc_low[wa_c]  <= wd_clow;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ctl_q   <= q_ctl;
			qaddr_q <= q_qaddr;
			baddr_q <= q_baddr;
			caddr_q <= q_caddr;
		end
		if (fire) begin
			out_q.status      <= ctl_q.status;
			out_q.max_quality <= hq_d;
			if (ctl_q.rd && ctl_q.status == ST_OK) begin
				out_q.match_count    <= 32'(sel_entry[COUNT_WIDTH-1:0]);
				out_q.mismatch_count <= 32'(sel_entry[EW-1:COUNT_WIDTH]);
			end else begin
				out_q.match_count    <= '0;
				out_q.mismatch_count <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_q       <= '0;
			hq_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			hq_q    <= hq_d;
			if (state_q == BK_CLEAR) clr_q <= clr_q + 1'b1;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### design/quality_match_mismatch_tally_top.sv
// Flow: an accepted transaction is queued; the back end pops it, reads the counter memories
//   (registered read), then increments, writes back and registers the result at out_data, and
//   finishes each transaction before it pops the next one from the queue.
// Reset: asynchronous, active low; clears control, config and max quality, then a clearing
//   pass over max(MAX_CYCLES*QUAL_BINS, 4*QUAL_BINS) counter addresses (32768 at default
//   sizes) zeroes all counters while in_ready stays low; config writes are taken.
module quality_match_mismatch_tally_top #(
	parameter int MAX_CYCLES  = qmmt_pkg::MAX_CYCLES_DEF,
	parameter int QUAL_BINS   = qmmt_pkg::QUAL_BINS_DEF,
	parameter int COUNT_WIDTH = qmmt_pkg::COUNT_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [9:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  qmmt_pkg::qmmt_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output qmmt_pkg::qmmt_out_t out_data
);
	import qmmt_pkg::*;

	localparam int QAW = $clog2(QUAL_BINS);
	localparam int BAW = $clog2(4*QUAL_BINS);
	localparam int CAW = $clog2(MAX_CYCLES*QUAL_BINS);
	localparam int FW  = $bits(qmmt_ctl_t) + QAW + BAW + CAW;

	qmmt_ctl_t      f_ctl, h_ctl;
	logic [QAW-1:0] f_qaddr, h_qaddr;
	logic [BAW-1:0] f_baddr, h_baddr;
	logic [CAW-1:0] f_caddr, h_caddr;
	logic [FW-1:0]  head;
	logic           full, not_empty, pop, clearing, push;

	// Front end: hold config, classify each transaction and form table addresses.
	qmmt_front #(
		.MAX_CYCLES(MAX_CYCLES),
		.QUAL_BINS (QUAL_BINS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_data  (in_data),
		.ctl      (f_ctl),
		.qaddr    (f_qaddr),
		.baddr    (f_baddr),
		.caddr    (f_caddr)
	);

	// Hold off new transactions while the counters are being cleared or the queue is full.
	assign in_ready = !full && !clearing;
	assign push     = in_valid && in_ready;

	qmmt_fifo #(
		.WIDTH(FW)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({f_ctl, f_caddr, f_baddr, f_qaddr}),
		.full     (full),
		.pop      (pop),
		.not_empty(not_empty),
		.head     (head)
	);

	assign {h_ctl, h_caddr, h_baddr, h_qaddr} = head;

	// Back end: update or read the histogram memories and hold the result.
	qmmt_back #(
		.MAX_CYCLES (MAX_CYCLES),
		.QUAL_BINS  (QUAL_BINS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (not_empty),
		.q_pop    (pop),
		.q_ctl    (h_ctl),
		.q_qaddr  (h_qaddr),
		.q_baddr  (h_baddr),
		.q_caddr  (h_caddr),
		.clearing (clearing),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

`ifndef SYNTHESIS
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !in_ready)
		else $error("transaction accepted during counter clear");

	a_fail_zero_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status != ST_OK) |->
		(out_data.match_count == '0 && out_data.mismatch_count == '0))
		else $error("nonzero counts on a failed transaction");

	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue popped while empty");
`endif

endmodule

### bench/tb_quality_match_mismatch_tally_top.sv
module tb_quality_match_mismatch_tally_top;
	timeunit 1ns;
	timeprecision 1ps;
	import qmmt_pkg::*;

	localparam int NCYC = MAX_CYCLES_DEF;
	localparam int NQ = QUAL_BINS_DEF;
	localparam longint COUNT_TOP = (64'd1 << COUNT_WIDTH_DEF) - 1;
	localparam int CYCLE_LIMIT = 400000;

	// Mirror of the tally histograms plus the queue of results still owed.
	class tally_scoreboard;
		longint unsigned sum_tab[6][NQ][2];
		longint unsigned cyc_tab[2][NCYC][NQ][2];
		logic [5:0] top_qual;
		logic [9:0] first_len, second_len;
		logic paired;
		qmmt_out_t owed[$];
		int errors;

		function new();
			foreach (sum_tab[i, j, k]) sum_tab[i][j][k] = 0;
			foreach (cyc_tab[i, j, q, k]) cyc_tab[i][j][q][k] = 0;
			top_qual = 0;
			first_len = 0;
			second_len = 0;
			paired = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [9:0] val);
			case (idx)
				CFG_FIRST: first_len = val;
				CFG_SECOND: second_len = val;
				CFG_PAIRED: paired = val[0];
				default: ;
			endcase
		endfunction

		function void bump(ref longint unsigned c);
			if (c < COUNT_TOP) c++;
		endfunction

		function qmmt_status_t count_base(qmmt_in_t t);
			int f, s, off, cyc, rows, bt, ph, kd;
			f = first_len;
			s = second_len;
			off = t.read_offset;
			if (t.masked) return ST_SKIP;
			if (t.second_mate && !paired) return ST_UNPAIRED;
			if (t.aligned_symbol == CH_S || t.aligned_symbol == CH_I) return ST_SKIP;
			if (t.aligned_symbol == CH_M) kd = 0;
			else if (t.aligned_symbol inside {CH_A, CH_C, CH_G, CH_T}) kd = 1;
			else return ST_BAD_SYM;
			if (t.qual_char < PHRED_OFFSET || t.qual_char - PHRED_OFFSET >= NQ)
				return ST_RANGE;
			ph = t.qual_char - PHRED_OFFSET;
			if (t.second_mate) cyc = t.reverse_strand ? f + (s - off - 1) : f + off;
			else cyc = t.reverse_strand ? f - off - 1 : off;
			rows = f + (paired ? s : 0);
			if (rows > NCYC) rows = NCYC;
			if (cyc < 0 || cyc >= rows) return ST_RANGE;
			bump(sum_tab[0][ph][kd]);
			bump(cyc_tab[0][cyc][ph][kd]);
			if (t.edit_distance <= LOW_EDIT_LIMIT) begin
				bump(sum_tab[1][ph][kd]);
				bump(cyc_tab[1][cyc][ph][kd]);
			end
			case (t.read_base)
				CH_A: bt = 0;
				CH_C: bt = 1;
				CH_G: bt = 2;
				CH_T: bt = 3;
				default: bt = -1;
			endcase
			if (bt >= 0) begin
				if (t.reverse_strand) bt = 3 - bt;
				bump(sum_tab[2 + bt][ph][kd]);
			end
			if (ph > top_qual) top_qual = (ph > QUAL_SAT) ? QUAL_SAT : ph[5:0];
			return ST_OK;
		endfunction

		function void note_input(qmmt_in_t t);
			qmmt_out_t r;
			r = '0;
			if (t.cmd) begin
				if (t.read_quality >= NQ) r.status = ST_RANGE;
				else if (t.table_select < TSEL_CYC_ALL) begin
					r.match_count = sum_tab[t.table_select][t.read_quality][0];
					r.mismatch_count = sum_tab[t.table_select][t.read_quality][1];
				end else if (t.read_cycle >= NCYC) r.status = ST_RANGE;
				else begin
					r.match_count = cyc_tab[t.table_select - 6][t.read_cycle][t.read_quality][0];
					r.mismatch_count =
						cyc_tab[t.table_select - 6][t.read_cycle][t.read_quality][1];
				end
			end else begin
				r.status = count_base(t);
			end
			r.max_quality = top_qual;
			owed = {owed, r};
		endfunction

		function void check_result(qmmt_out_t got);
			qmmt_out_t e;
			if (owed.size() == 0) begin
				$error("result with nothing expected: %p", got);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (got.status !== e.status) begin
				$error("status expected %0d actual %0d", e.status, got.status);
				errors++;
			end
			if (got.match_count !== e.match_count) begin
				$error("match_count expected %0d actual %0d", e.match_count, got.match_count);
				errors++;
			end
			if (got.mismatch_count !== e.mismatch_count) begin
				$error("mismatch_count expected %0d actual %0d", e.mismatch_count,
					got.mismatch_count);
				errors++;
			end
			if (got.max_quality !== e.max_quality) begin
				$error("max_quality expected %0d actual %0d", e.max_quality, got.max_quality);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [9:0] cfg_data;
	logic in_valid, in_ready, out_valid, out_ready;
	qmmt_in_t in_data;
	qmmt_out_t out_data;

	tally_scoreboard board;
	int cycles = 0;
	bit calm;        // stretch with no idling on either side
	int hold_left;   // receiver hold-off cycles still to go
	bit hold_req;

	quality_match_mismatch_tally_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Count cycles and bail out on a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver: random stalls, plus long hold-offs, repeated for as long as hold_req is set.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
		end else begin
			if (out_valid && out_ready) board.check_result(out_data);
			if (hold_req && hold_left == 0) begin
				hold_left <= 60;
				out_ready <= 1'b0;
			end else if (hold_left > 1) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				hold_left <= 0;
				out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 6);
			end
		end
	end

	// Write one register; only called while the block holds no work.
	task automatic write_reg(logic [1:0] idx, logic [9:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_reg(idx, val);
	endtask

	// Offer one transaction, with a random gap ahead, and hold it until taken.
	task automatic send(qmmt_in_t t);
		if (!calm && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= t;
		do @(posedge clk); while (!in_ready);
		board.note_input(t);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.owed.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic qmmt_in_t rand_item(bit wellformed);
		qmmt_in_t t;
		logic [7:0] syms[7];
		logic [7:0] bases[4];
		syms = '{CH_M, CH_M, CH_M, CH_A, CH_C, CH_G, CH_T};
		bases = '{CH_A, CH_C, CH_G, CH_T};
		t = qmmt_in_t'({$urandom, $urandom, $urandom});
		if (wellformed) begin
			t.cmd = ($urandom_range(4) == 0);
			t.masked = ($urandom_range(19) == 0);
			t.qual_char = 8'($urandom_range(33, 96));
			t.aligned_symbol = ($urandom_range(15) == 0) ? CH_S : syms[$urandom_range(6)];
			t.read_base = ($urandom_range(15) == 0) ? 8'($urandom) : bases[$urandom_range(3)];
			t.read_offset = 9'($urandom_range(40));
			t.edit_distance = 8'($urandom_range(5));
			t.read_cycle = 9'($urandom_range(90));
			t.read_quality = 6'($urandom_range(0, 15));
		end
		return t;
	endfunction

	task automatic directed();
		qmmt_in_t t;
		logic [7:0] syms[6];
		syms = '{CH_M, CH_A, CH_C, CH_G, CH_T, CH_I};
		for (int i = 0; i < 6; i++) begin
			t = '0;
			t.qual_char = (i == 0) ? 8'd33 : (i == 1) ? 8'd96 : 8'd60;
			t.aligned_symbol = syms[i];
			t.read_base = (i == 2) ? 8'h4E : CH_G;
			t.read_offset = 9'(i);
			t.reverse_strand = i[0];
			t.edit_distance = (i == 3) ? 8'hFF : 8'd0;
			send(t);
		end
		t = '0; t.qual_char = 8'd40; t.aligned_symbol = CH_M; t.masked = 1; send(t);
		t.masked = 0; t.second_mate = 1; send(t);
		t.second_mate = 0; t.aligned_symbol = 8'h58; send(t);
		t.aligned_symbol = CH_M; t.qual_char = 8'd32; send(t);
		t.qual_char = 8'd97; send(t);
		t.qual_char = 8'hFF; send(t);
		t.qual_char = 8'd50; t.read_offset = 9'd511; send(t);
		t.read_offset = 0; t.reverse_strand = 1; t.second_mate = 1; send(t);
		for (int s = 0; s < 8; s++) begin
			t = '0;
			t.cmd = 1;
			t.table_select = 3'(s);
			t.read_quality = (s == 0) ? 6'd0 : (s == 1) ? 6'd63 : 6'd27;
			t.read_cycle = (s == 6) ? 9'd0 : 9'd511;
			send(t);
		end
	endtask

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++)
			send(rand_item($urandom_range(9) != 0));
	endtask

	initial begin
		board = new();
		calm = 0;
		hold_req = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_FIRST;
		cfg_data = '0;
		in_valid = 0;
		in_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Reset settings first: every tally lands out of range.
		directed();
		drain();
		write_reg(CFG_FIRST, 10'd40);
		write_reg(CFG_SECOND, 10'd41);
		write_reg(CFG_PAIRED, 10'd1);
		directed();
		random_phase(200);
		hold_req <= 1'b1;
		random_phase(40);
		hold_req <= 1'b0;
		drain();
		write_reg(CFG_PAIRED, 10'd0);
		calm = 1;
		random_phase(150);
		calm = 0;
		drain();
		write_reg(CFG_FIRST, 10'd512);
		write_reg(CFG_SECOND, 10'd512);
		write_reg(CFG_PAIRED, 10'd1);
		random_phase(150);
		drain();
		write_reg(CFG_FIRST, 10'd0);
		write_reg(CFG_SECOND, 10'd30);
		random_phase(150);
		drain();

		if (board.errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule

### filelist.f
design/qmmt_pkg.sv
design/qmmt_front.sv
design/qmmt_fifo.sv
design/qmmt_back.sv
design/quality_match_mismatch_tally_top.sv
bench/tb_quality_match_mismatch_tally_top.sv
